[hdl/lks_pkg.sv]
// package for the lru key-value store: request and response types, codes, defaults
package lks_pkg;

  // default number of slots
  localparam int unsigned LKS_CAPACITY = 16;

  // width and reset value of the active entry limit register
  localparam int unsigned CFG_W         = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  // operation codes
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_SET = 1'b1;

  // value returned by a get that misses
  localparam logic signed [31:0] MISS_VALUE = -32'sd1;

  // one request
  typedef struct packed {
    logic               kind;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } lks_req_t;

  // one response
  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } lks_rsp_t;

endpackage

[hdl/lru_key_value_store.sv]
// fully associative key-value store with least-recently-used replacement
//
//   channel  ports                       handshake
//   request  start, busy, in_req         taken when start is high and busy is low
//   response out_strobe, out_rsp         one cycle per response, no back-pressure
//   config   cfg_wr_en, cfg_wr_data      written on any edge with cfg_wr_en high
//
// one request per cycle sustained; busy is never raised
// a request is registered at the accepting edge, searched and applied to the slots in the
// next cycle, and its response is shown in the cycle after that
// the parallel key compare and the recency rank update over all slots set that cycle
// rst_n (synchronous) clears the valid bits, ranks, fill count and limit (to 16)
// the receiver cannot stall: out_strobe is high for exactly one cycle per response
module lru_key_value_store
  import lks_pkg::*;
#(
  parameter int unsigned CAPACITY = LKS_CAPACITY
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  lks_req_t         in_req,
  output logic             out_strobe,
  output lks_rsp_t         out_rsp,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int unsigned RW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // request register
  logic              in_valid_r;
  lks_req_t          req_r;

  // slot state
  logic [CAPACITY-1:0]        valid_r, valid_nxt;
  logic signed [31:0]         key_r   [CAPACITY];
  logic signed [31:0]         value_r [CAPACITY];
  logic [RW-1:0]              rank_r  [CAPACITY];
  logic [RW-1:0]              rank_nxt[CAPACITY];
  logic [CNT_W-1:0]           fill_r, fill_nxt;
  logic [CFG_W-1:0]           active_r;

  // response register
  logic              out_strobe_r;
  lks_rsp_t          rsp_r, rsp_nxt;

  // search results
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] free_oh;
  logic [CAPACITY-1:0] old_oh;
  logic [CAPACITY-1:0] target;
  logic                hit;
  logic                use_free;
  logic                is_set;
  logic                do_update;
  logic                evict;
  logic signed [31:0]  hit_value;
  logic signed [31:0]  old_key;
  logic [RW-1:0]       hit_rank;
  logic [RW-1:0]       old_rank;
  logic [CNT_W-1:0]    promo_rank;
  logic [CMP_W-1:0]    limit;
  logic [CMP_W-1:0]    act_ext;

  assign busy       = 1'b0;
  assign out_strobe = out_strobe_r;
  assign out_rsp    = rsp_r;

  // effective entry limit, clamped to one..CAPACITY
  always_comb begin
    act_ext = CMP_W'(active_r);
    if (act_ext == '0) begin
      limit = CMP_W'(1);
    end else if (act_ext > CMP_W'(CAPACITY)) begin
      limit = CMP_W'(CAPACITY);
    end else begin
      limit = act_ext;
    end
  end

  assign use_free = CMP_W'(fill_r) < limit;
  assign old_rank = RW'(fill_r - CNT_W'(1));
  assign free_oh  = ~valid_r & (valid_r + CAPACITY'(1));

  // parallel key compare, oldest slot and one-hot selects
  always_comb begin
    hit_value = '0;
    old_key   = '0;
    hit_rank  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]  = valid_r[i] && (key_r[i] == req_r.key);
      old_oh[i] = valid_r[i] && (rank_r[i] == old_rank);
      if (match[i]) begin
        hit_value = hit_value | value_r[i];
        hit_rank  = hit_rank | rank_r[i];
      end
      if (old_oh[i]) begin
        old_key = old_key | key_r[i];
      end
    end
  end

  assign hit       = |match;
  assign is_set    = (req_r.kind == KIND_SET);
  assign do_update = in_valid_r && (hit || is_set);
  assign evict     = is_set && !hit && !use_free;

  // slot to promote and the rank it leaves behind
  always_comb begin
    if (hit) begin
      target     = match;
      promo_rank = CNT_W'(hit_rank);
    end else if (use_free) begin
      target     = free_oh;
      promo_rank = fill_r;
    end else begin
      target     = old_oh;
      promo_rank = CNT_W'(old_rank);
    end
  end

  // next valid bits, ranks and fill
  always_comb begin
    valid_nxt = valid_r;
    fill_nxt  = fill_r;
    for (int i = 0; i < CAPACITY; i++) begin
      rank_nxt[i] = rank_r[i];
      if (do_update) begin
        if (target[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (CNT_W'(rank_r[i]) < promo_rank)) begin
          rank_nxt[i] = rank_r[i] + RW'(1);
        end
      end
    end
    if (do_update && is_set && !hit && use_free) begin
      valid_nxt = valid_r | free_oh;
      fill_nxt  = fill_r + CNT_W'(1);
    end
  end

  // response fields
  always_comb begin
    rsp_nxt.hit         = hit;
    rsp_nxt.evicted     = evict;
    rsp_nxt.evicted_key = evict ? old_key : 32'sd0;
    if (is_set) begin
      rsp_nxt.read_value = req_r.value;
    end else if (hit) begin
      rsp_nxt.read_value = hit_value;
    end else begin
      rsp_nxt.read_value = MISS_VALUE;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      valid_r      <= '0;
      fill_r       <= '0;
      active_r     <= CFG_RESET;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      in_valid_r   <= start && !busy;
      out_strobe_r <= in_valid_r;
      valid_r      <= valid_nxt;
      fill_r       <= fill_nxt;
      if (cfg_wr_en) begin
        active_r <= cfg_wr_data;
      end
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_req;
    end
    if (in_valid_r) begin
      rsp_r <= rsp_nxt;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_update && is_set && target[i]) begin
        key_r[i]   <= req_r.key;
        value_r[i] <= req_r.value;
      end
    end
  end

endmodule

[tb/tb.sv]
// self-checking testbench for the lru key-value store: random and directed requests
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lks_pkg::*;

  // cycles with no request taken and no response seen before giving up
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned POOL_SIZE = 24;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  lks_req_t         in_req = '0;
  logic             out_strobe;
  lks_rsp_t         out_rsp;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = CFG_RESET;

  lru_key_value_store #(
    .CAPACITY(LKS_CAPACITY)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_strobe(out_strobe),
    .out_rsp(out_rsp),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the store
  logic             slot_used [LKS_CAPACITY];
  logic [31:0]      slot_key [LKS_CAPACITY];
  logic [31:0]      slot_val [LKS_CAPACITY];
  int unsigned      slot_age [LKS_CAPACITY];
  int unsigned      used_count;
  logic [CFG_W-1:0] limit_reg;

  lks_req_t    req_pending [$];
  lks_rsp_t    rsp_expected [$];
  logic [31:0] key_pool [POOL_SIZE];
  int unsigned idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet = 0;

  // register value to usable slot count: zero acts as one, clipped at capacity
  function automatic int unsigned effective_limit(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > LKS_CAPACITY) return LKS_CAPACITY;
    return 32'(v);
  endfunction

  // slot s becomes most recent, every younger valid slot ages by one
  function automatic void make_newest(int s);
    int unsigned r;
    r = slot_age[s];
    for (int i = 0; i < LKS_CAPACITY; i++) begin
      if (i != s && slot_used[i] && slot_age[i] < r) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  // expected response of one request, applying it to the shadow store
  function automatic lks_rsp_t lru_predict(lks_req_t r);
    lks_rsp_t o;
    int s;
    int t;
    o = '0;
    s = -1;
    t = -1;
    for (int i = LKS_CAPACITY - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == r.key) s = i;
    end
    o.hit = (s >= 0);
    if (r.kind == KIND_GET) begin
      if (s >= 0) begin
        make_newest(s);
        o.read_value = slot_val[s];
      end else begin
        o.read_value = MISS_VALUE;
      end
    end else begin
      o.read_value = r.value;
      if (s >= 0) begin
        make_newest(s);
        slot_val[s] = r.value;
      end else begin
        // lowest free slot while below the limit
        if (used_count < effective_limit(limit_reg)) begin
          for (int i = LKS_CAPACITY - 1; i >= 0; i--) begin
            if (!slot_used[i]) t = i;
          end
        end
        if (t < 0) begin
          // displace the least recent entry
          for (int i = 0; i < LKS_CAPACITY; i++) begin
            if (slot_used[i] && (t < 0 || slot_age[i] > slot_age[t])) t = i;
          end
          o.evicted = 1'b1;
          o.evicted_key = slot_key[t];
        end else begin
          slot_used[t] = 1'b1;
          slot_age[t] = used_count;
          used_count++;
        end
        slot_key[t] = r.key;
        slot_val[t] = r.value;
        make_newest(t);
      end
    end
    return o;
  endfunction

  function automatic lks_req_t req_of(logic kind, logic [31:0] key, logic [31:0] value);
    lks_req_t r;
    r.kind = kind;
    r.key = key;
    r.value = value;
    return r;
  endfunction

  // mostly keys from a small pool so hits and evictions are common
  function automatic lks_req_t random_req(int unsigned span);
    lks_req_t r;
    r.kind = $urandom_range(1) ? KIND_SET : KIND_GET;
    r.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(span)] : $urandom;
    case ($urandom_range(9))
      0: r.value = 32'h8000_0000;
      1: r.value = 32'h7fff_ffff;
      default: r.value = $urandom;
    endcase
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    logic take;
    logic go;
    lks_req_t nxt;
    take = rst_n && start && !busy;
    go = start && !take;
    nxt = in_req;
    if (take) rsp_expected.push_back(lru_predict(in_req));
    if (!go && rst_n && req_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
      nxt = req_pending.pop_front();
      go = 1'b1;
    end
    start <= go;
    in_req <= nxt;
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // response monitor
  always @(posedge clk) begin
    lks_rsp_t want;
    if (rst_n && out_strobe) begin
      if (rsp_expected.size() == 0) begin
        $display("%0t: response expected none got %h", $time, out_rsp);
        mismatches++;
      end else begin
        want = rsp_expected.pop_front();
        check_field("hit", 32'(want.hit), 32'(out_rsp.hit));
        check_field("read_value", want.read_value, out_rsp.read_value);
        check_field("evicted", 32'(want.evicted), 32'(out_rsp.evicted));
        check_field("evicted_key", want.evicted_key, out_rsp.evicted_key);
      end
    end
  end

  // watchdog on lack of progress
  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_strobe)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("lru_key_value_store regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // waits until every pending request is sent and every response is back
  task automatic drain_all();
    do @(negedge clk); while (req_pending.size() != 0 || start || rsp_expected.size() != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // limit register write, only with the store idle
  task automatic write_limit(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = v;
    @(negedge clk);
  endtask

  task automatic run_random(logic [CFG_W-1:0] lim, int unsigned idle, int unsigned count);
    int unsigned span;
    write_limit(lim);
    idle_pct = idle;
    span = effective_limit(lim) + 4;
    if (span > POOL_SIZE - 1) span = POOL_SIZE - 1;
    repeat (count) req_pending.push_back(random_req(span));
    drain_all();
  endtask

  // stimulus sequence
  initial begin
    used_count = 0;
    limit_reg = CFG_RESET;
    for (int i = 0; i < LKS_CAPACITY; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_val[i] = '0;
      slot_age[i] = 0;
    end
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_pct = 7;

    // empty store, key and value extremes, overwrite
    req_pending.push_back(req_of(KIND_GET, 32'h0000_0000, 32'h1234_5678));
    req_pending.push_back(req_of(KIND_SET, 32'h8000_0000, 32'h7fff_ffff));
    req_pending.push_back(req_of(KIND_SET, 32'h7fff_ffff, 32'h8000_0000));
    req_pending.push_back(req_of(KIND_SET, 32'h0000_0000, 32'h0000_0000));
    req_pending.push_back(req_of(KIND_SET, 32'hffff_ffff, 32'hffff_ffff));
    req_pending.push_back(req_of(KIND_GET, 32'h8000_0000, 32'h0000_0000));
    req_pending.push_back(req_of(KIND_GET, 32'hffff_ffff, 32'hffff_ffff));
    req_pending.push_back(req_of(KIND_GET, 32'h0000_3039, 32'h0000_0000));
    req_pending.push_back(req_of(KIND_SET, 32'h7fff_ffff, 32'h5555_5555));
    req_pending.push_back(req_of(KIND_GET, 32'h7fff_ffff, 32'haaaa_aaaa));
    req_pending.push_back(req_of(KIND_SET, 32'h0000_0005, 32'haaaa_aaaa));
    drain_all();

    // limit lowered below the fill: each new key evicts one entry
    write_limit(2);
    req_pending.push_back(req_of(KIND_SET, 32'h0000_0006, 32'h0000_0001));
    req_pending.push_back(req_of(KIND_SET, 32'h0000_0007, 32'h0000_0002));
    req_pending.push_back(req_of(KIND_GET, 32'h0000_0006, 32'h0000_0000));
    req_pending.push_back(req_of(KIND_SET, 32'h0000_0008, 32'h0000_0003));
    req_pending.push_back(req_of(KIND_GET, 32'h0000_0007, 32'h0000_0000));
    drain_all();

    // zero limit acts as one
    write_limit(0);
    req_pending.push_back(req_of(KIND_SET, 32'h0000_0009, 32'h0000_0004));
    req_pending.push_back(req_of(KIND_GET, 32'h0000_0009, 32'h0000_0000));
    req_pending.push_back(req_of(KIND_SET, 32'h0000_000a, 32'h0000_0005));
    drain_all();

    // random phases over a range of limits and sender gaps
    run_random(31, 7, 100);
    run_random(4, 7, 100);
    run_random(1, 7, 100);
    run_random(16, 47, 100);
    run_random(3, 47, 100);
    run_random(8, 47, 100);
    run_random(0, 0, 100);
    run_random(2, 0, 100);
    run_random(16, 0, 100);

    if (mismatches == 0) begin
      $display("lru_key_value_store regression: pass");
    end else begin
      $display("lru_key_value_store regression: fail");
    end
    $finish;
  end

endmodule
